// ===== hdl/periodic_priority_task_dispatcher_top_macros.svh =====
// ---------------------------------------------------------------------------
// periodic priority task dispatcher assertion macros
// shared concurrent assertion wrappers, clocked on clk, held off in rst
// ---------------------------------------------------------------------------
`ifndef PERIODIC_PRIORITY_TASK_DISPATCHER_TOP_MACROS_SVH
`define PERIODIC_PRIORITY_TASK_DISPATCHER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PPD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppd assertion failed: same-cycle check");

// next-cycle implication
`define PPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppd assertion failed: next-cycle check");

`else

`define PPD_ASSERT_SAME(label, ante, cons)
`define PPD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/ppd_pkg.sv =====
// ---------------------------------------------------------------------------
// ppd_pkg
// types and constants shared by the task dispatcher modules
// ---------------------------------------------------------------------------
package ppd_pkg;

  localparam int REG_SLOTS  = 3;
  localparam int TICK_W     = 16;
  localparam int PRIO_W     = 8;
  localparam int COUNT_W    = 2;
  localparam int TASK_IDX_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_2 = 3'd6;

  typedef logic [REG_SLOTS-1:0][TICK_W-1:0] period_arr_t;
  typedef logic [REG_SLOTS-1:0][PRIO_W-1:0] prio_arr_t;

  // verdict of the shared slot unit for one slot
  typedef struct packed {
    logic ready;  // ready mark after the elapsed check
    logic take;   // slot beats the best so far
  } slot_eval_t;

endpackage

// ===== hdl/periodic_priority_task_dispatcher_top.sv =====
// ---------------------------------------------------------------------------
// periodic_priority_task_dispatcher_top
// fixed-priority periodic task dispatcher, one scheduling pass per beat
// ---------------------------------------------------------------------------
// Each input beat is one scheduling pass at the given tick. The block walks
// the enabled slots (min(task_count, TASK_SLOTS)) one per cycle through a
// single shared slot unit that does the wrapped elapsed-vs-period check and
// the priority compare, then a commit state clears the winner's ready mark,
// records its last run tick and loads the result register. The input stalls
// for the whole pass. The result sits in an output register, so a new pass
// may start while the previous result still waits; the commit state waits
// only if that register is still full.
// ---------------------------------------------------------------------------
`include "periodic_priority_task_dispatcher_top_macros.svh"

module periodic_priority_task_dispatcher_top #(
  parameter int TASK_SLOTS = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  // scheduling pass channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ppd_pkg::TICK_W-1:0]       current_tick,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             dispatched,
  output logic [ppd_pkg::TASK_IDX_W-1:0]   task_index,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [ppd_pkg::COUNT_W-1:0] SLOTS_CNT = ppd_pkg::COUNT_W'(TASK_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state;

  // configuration
  logic [ppd_pkg::COUNT_W-1:0] task_count;
  ppd_pkg::period_arr_t        period;
  ppd_pkg::prio_arr_t          prio;
  logic [ppd_pkg::COUNT_W-1:0] eff_count;

  // per-slot state
  logic [TASK_SLOTS-1:0]       ready_mark;
  logic [ppd_pkg::TICK_W-1:0]  last_run [TASK_SLOTS];

  // pass working registers
  logic [ppd_pkg::TICK_W-1:0]  tick;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            best;
  logic [ppd_pkg::PRIO_W-1:0]  best_prio;
  logic                        found;

  // shared unit hookup
  logic [ppd_pkg::COUNT_W-1:0] reg_sel;
  logic [ppd_pkg::PRIO_W-1:0]  prio_cur;
  ppd_pkg::slot_eval_t         eval;
  logic                        last_slot;
  logic                        out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // a count above the slot count acts as the slot count
  assign eff_count = (task_count > SLOTS_CNT) ? SLOTS_CNT : task_count;
  assign reg_sel   = ppd_pkg::COUNT_W'(idx);
  assign prio_cur  = prio[reg_sel];
  assign last_slot = ((reg_sel + 2'd1) == eff_count);

  ppd_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cfg_valid && cfg_ready),
    .wr_index   (cfg_index),
    .wr_data    (cfg_data),
    .task_count (task_count),
    .period     (period),
    .prio       (prio)
  );

  ppd_slot_unit u_slot (
    .tick      (tick),
    .last_run  (last_run[idx]),
    .period    (period[reg_sel]),
    .ready_in  (ready_mark[idx]),
    .prio      (prio_cur),
    .best_prio (best_prio),
    .found     (found),
    .eval      (eval)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      ready_mark <= '0;
      found      <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        last_run[i] <= '0;
      end
    end else begin
      // result taken downstream; the commit arm reloads it when it fires
      if (out_valid && !out_stall && (state != S_COMMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tick      <= current_tick;
            idx       <= '0;
            best      <= '0;
            best_prio <= '0;
            found     <= 1'b0;
            // no enabled slot: straight to a no-dispatch result
            state     <= (eff_count == '0) ? S_COMMIT : S_SCAN;
          end
        end
        S_SCAN: begin
          // one slot per cycle through the shared unit
          ready_mark[idx] <= eval.ready;
          if (eval.take) begin
            found     <= 1'b1;
            best      <= idx;
            best_prio <= prio_cur;
          end
          if (last_slot) begin
            state <= S_COMMIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_COMMIT: begin
          // wait for room in the result register
          if (out_free) begin
            out_valid  <= 1'b1;
            dispatched <= found;
            task_index <= found ? ppd_pkg::TASK_IDX_W'(best) : '0;
            if (found) begin
              ready_mark[best] <= 1'b0;
              last_run[best]   <= tick;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // scan never walks past the enabled slots
  `PPD_ASSERT_SAME(a_scan_in_range, state == S_SCAN, reg_sel < eff_count)
  // a dispatched slot is always an enabled one
  `PPD_ASSERT_SAME(a_out_slot_enabled, out_valid && dispatched, task_index < eff_count)
  // empty pass reports slot zero
  `PPD_ASSERT_SAME(a_no_dispatch_zero, out_valid && !dispatched, task_index == '0)
  // the winner leaves the commit with its ready mark cleared
  `PPD_ASSERT_NEXT(a_winner_cleared, state == S_COMMIT && out_free && found, !ready_mark[$past(best)])

endmodule

// ===== hdl/ppd_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// ppd_cfg_regs
// configuration register file: task count, periods and priorities
// ---------------------------------------------------------------------------
module ppd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [ppd_pkg::CFG_DATA_W-1:0]   wr_data,
  output logic [ppd_pkg::COUNT_W-1:0]      task_count,
  output ppd_pkg::period_arr_t             period,
  output ppd_pkg::prio_arr_t               prio
);

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      period     <= '0;
      prio       <= '0;
    end else if (wr_en) begin
      case (wr_index)
        ppd_pkg::REG_TASK_COUNT: task_count <= wr_data[ppd_pkg::COUNT_W-1:0];
        ppd_pkg::REG_PERIOD_0:   period[0]  <= wr_data;
        ppd_pkg::REG_PERIOD_1:   period[1]  <= wr_data;
        ppd_pkg::REG_PERIOD_2:   period[2]  <= wr_data;
        ppd_pkg::REG_PRIORITY_0: prio[0]    <= wr_data[ppd_pkg::PRIO_W-1:0];
        ppd_pkg::REG_PRIORITY_1: prio[1]    <= wr_data[ppd_pkg::PRIO_W-1:0];
        ppd_pkg::REG_PRIORITY_2: prio[2]    <= wr_data[ppd_pkg::PRIO_W-1:0];
        default: ;  // unknown index, dropped
      endcase
    end
  end

endmodule

// ===== hdl/ppd_slot_unit.sv =====
// ---------------------------------------------------------------------------
// ppd_slot_unit
// shared per-slot evaluator: wrapped elapsed check and priority compare
// ---------------------------------------------------------------------------
module ppd_slot_unit (
  input  logic [ppd_pkg::TICK_W-1:0] tick,
  input  logic [ppd_pkg::TICK_W-1:0] last_run,
  input  logic [ppd_pkg::TICK_W-1:0] period,
  input  logic                       ready_in,
  input  logic [ppd_pkg::PRIO_W-1:0] prio,
  input  logic [ppd_pkg::PRIO_W-1:0] best_prio,
  input  logic                       found,
  output ppd_pkg::slot_eval_t        eval
);

  logic [ppd_pkg::TICK_W-1:0] elapsed;

  // modulo 2^16 by plain wraparound
  assign elapsed    = tick - last_run;
  assign eval.ready = ready_in || (elapsed >= period);
  // strict less-than keeps the lower index on a tie
  assign eval.take  = eval.ready && (!found || (prio < best_prio));

endmodule

// ===== tb/sv/periodic_priority_task_dispatcher_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// periodic_priority_task_dispatcher_top_tb
// self-checking bench for the fixed-priority periodic task dispatcher
// ---------------------------------------------------------------------------
// Drives scheduling passes with a mostly advancing tick (small steps, wraps
// and random jumps), reprograms slot count, periods and priorities between
// phases while the block is idle, and checks every result beat against a
// small dispatch predictor kept in a scoreboard class. Sender bursts and
// receiver stalls are random so that gaps hit every cycle of a pass.
// ---------------------------------------------------------------------------
module periodic_priority_task_dispatcher_top_tb;

  // index above the register file, writes to it are dropped
  localparam logic [ppd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SLOTS        = 3;
  localparam int RANDOM_PASSES = 1800;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    logic                           dispatched;
    logic [ppd_pkg::TASK_IDX_W-1:0] task_index;
  } dispatch_t;

  // -------------------------------------------------------------------------
  // scoreboard: mirrors the register file and the slot state, predicts the
  // dispatch for every accepted pass and matches result beats in order
  // -------------------------------------------------------------------------
  class dispatch_scoreboard;
    logic [ppd_pkg::COUNT_W-1:0] task_count;
    logic [ppd_pkg::TICK_W-1:0]  period [SLOTS];
    logic [ppd_pkg::PRIO_W-1:0]  prio [SLOTS];
    logic [ppd_pkg::TICK_W-1:0]  last_run [SLOTS];
    bit                          ready [SLOTS];
    dispatch_t                   expected_dispatches[$];
    int                          error_count;

    function new();
      task_count  = '0;
      error_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
        period[i]   = '0;
        prio[i]     = '0;
        last_run[i] = '0;
        ready[i]    = 0;
      end
    endfunction

    function void note_config(logic [ppd_pkg::CFG_IDX_W-1:0] idx,
                              logic [ppd_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ppd_pkg::REG_TASK_COUNT: task_count = data[ppd_pkg::COUNT_W-1:0];
        ppd_pkg::REG_PERIOD_0:   period[0]  = data[ppd_pkg::TICK_W-1:0];
        ppd_pkg::REG_PERIOD_1:   period[1]  = data[ppd_pkg::TICK_W-1:0];
        ppd_pkg::REG_PERIOD_2:   period[2]  = data[ppd_pkg::TICK_W-1:0];
        ppd_pkg::REG_PRIORITY_0: prio[0]    = data[ppd_pkg::PRIO_W-1:0];
        ppd_pkg::REG_PRIORITY_1: prio[1]    = data[ppd_pkg::PRIO_W-1:0];
        ppd_pkg::REG_PRIORITY_2: prio[2]    = data[ppd_pkg::PRIO_W-1:0];
        default: ;
      endcase
    endfunction

    // one scheduling pass: refresh ready marks, pick the winner, commit it
    function void note_pass(logic [ppd_pkg::TICK_W-1:0] tick);
      int                         enabled;
      int                         best;
      bit                         found;
      logic [ppd_pkg::PRIO_W-1:0] best_prio;
      logic [ppd_pkg::TICK_W-1:0] elapsed;
      dispatch_t                  exp_beat;
      enabled   = (task_count > SLOTS) ? SLOTS : int'(task_count);
      found     = 0;
      best      = 0;
      best_prio = '0;
      for (int i = 0; i < enabled; i++) begin
        elapsed = tick - last_run[i];
        if (elapsed >= period[i]) ready[i] = 1;
      end
      for (int i = 0; i < enabled; i++) begin
        if (ready[i] && (!found || prio[i] < best_prio)) begin
          found     = 1;
          best      = i;
          best_prio = prio[i];
        end
      end
      if (found) begin
        ready[best]         = 0;
        last_run[best]      = tick;
        exp_beat.dispatched = 1'b1;
        exp_beat.task_index = ppd_pkg::TASK_IDX_W'(best);
      end else begin
        exp_beat.dispatched = 1'b0;
        exp_beat.task_index = '0;
      end
      expected_dispatches.push_back(exp_beat);
    endfunction

    function void check_result(logic disp, logic [ppd_pkg::TASK_IDX_W-1:0] idx);
      dispatch_t exp_beat;
      if (expected_dispatches.size() == 0) begin
        $display("%0t: result beat with nothing expected, dispatched %0d task_index %0d",
                 $time, disp, idx);
        error_count++;
        return;
      end
      exp_beat = expected_dispatches.pop_front();
      if (disp !== exp_beat.dispatched) begin
        $display("%0t: dispatched mismatch, expected %0d, actual %0d",
                 $time, exp_beat.dispatched, disp);
        error_count++;
      end
      if (idx !== exp_beat.task_index) begin
        $display("%0t: task_index mismatch, expected %0d, actual %0d",
                 $time, exp_beat.task_index, idx);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_dispatches.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // signals and dut
  // -------------------------------------------------------------------------
  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic [ppd_pkg::TICK_W-1:0]     current_tick;
  logic                           out_valid;
  logic                           out_stall;
  logic                           dispatched;
  logic [ppd_pkg::TASK_IDX_W-1:0] task_index;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ppd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ppd_pkg::CFG_DATA_W-1:0] cfg_data;

  dispatch_scoreboard         sb;
  logic [ppd_pkg::TICK_W-1:0] tick_now;
  int                         cycle_count = 0;

  periodic_priority_task_dispatcher_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .current_tick (current_tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dispatched   (dispatched),
    .task_index   (task_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("periodic_priority_task_dispatcher_top_tb: done, errors");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // result side: check every accepted beat, stall on a mode pattern
  // -------------------------------------------------------------------------
  int stall_mode   = 0;
  int stall_left   = 0;
  bit stall_toggle = 0;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(dispatched, task_index);
    if (stall_left == 0) begin
      // pick a new stall mode: none, light, heavy, every other cycle
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    stall_toggle = ~stall_toggle;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= stall_toggle;
    endcase
  end

  // -------------------------------------------------------------------------
  // drivers
  // -------------------------------------------------------------------------
  // one register beat; cfg_valid stays high for back-to-back writes
  task automatic write_reg(input logic [ppd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
  endtask

  task automatic end_reg_writes();
    cfg_valid <= 1'b0;
  endtask

  // one pass beat; in_valid stays high so the next beat can follow at once
  task automatic send_pass(input logic [ppd_pkg::TICK_W-1:0] tick);
    in_valid     <= 1'b1;
    current_tick <= tick;
    do @(posedge clk); while (in_stall);
    sb.note_pass(tick);
  endtask

  // wait until every predicted dispatch has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // mostly small forward steps, some repeats, some random jumps
  function automatic logic [ppd_pkg::TICK_W-1:0] advance_tick(
      input logic [ppd_pkg::TICK_W-1:0] t);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return ppd_pkg::TICK_W'($urandom);
    if (r < 15) return t;
    return t + ppd_pkg::TICK_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [ppd_pkg::TICK_W-1:0] random_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 60) return ppd_pkg::TICK_W'($urandom_range(1, 12));
    if (r < 80) return ppd_pkg::TICK_W'($urandom_range(13, 200));
    if (r < 90) return '1;
    return ppd_pkg::TICK_W'($urandom);
  endfunction

  function automatic logic [ppd_pkg::CFG_DATA_W-1:0] random_priority_data();
    int                         r;
    logic [ppd_pkg::PRIO_W-1:0] p;
    r = $urandom_range(0, 99);
    if (r < 40)      p = ppd_pkg::PRIO_W'($urandom_range(0, 2));   // lots of ties
    else if (r < 50) p = '0;
    else if (r < 60) p = '1;
    else             p = ppd_pkg::PRIO_W'($urandom);
    // upper data bits are junk the block must drop
    return {ppd_pkg::PRIO_W'($urandom), p};
  endfunction

  // new settings for a random phase; the block is idle here
  task automatic program_phase();
    logic [ppd_pkg::COUNT_W-1:0] count;
    int                          r;
    r = $urandom_range(0, 9);
    count = (r == 0) ? 2'd0 : (r < 3) ? 2'd1 : (r < 5) ? 2'd2 : 2'd3;
    if ($urandom_range(0, 9) < 7)
      write_reg(ppd_pkg::REG_TASK_COUNT, {14'($urandom), count});
    if ($urandom_range(0, 9) < 7) write_reg(ppd_pkg::REG_PERIOD_0, random_period());
    if ($urandom_range(0, 9) < 7) write_reg(ppd_pkg::REG_PERIOD_1, random_period());
    if ($urandom_range(0, 9) < 7) write_reg(ppd_pkg::REG_PERIOD_2, random_period());
    if ($urandom_range(0, 9) < 7)
      write_reg(ppd_pkg::REG_PRIORITY_0, random_priority_data());
    if ($urandom_range(0, 9) < 7)
      write_reg(ppd_pkg::REG_PRIORITY_1, random_priority_data());
    if ($urandom_range(0, 9) < 7)
      write_reg(ppd_pkg::REG_PRIORITY_2, random_priority_data());
    if ($urandom_range(0, 9) == 0)
      write_reg(REG_UNUSED, ppd_pkg::CFG_DATA_W'($urandom));
    end_reg_writes();
  endtask

  // a phase of passes sent in bursts with random gaps between them
  task automatic run_phase(input int passes);
    int burst;
    int gap;
    bit no_gaps;
    no_gaps = ($urandom_range(0, 3) == 0);
    while (passes > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > passes) burst = passes;
      for (int j = 0; j < burst; j++) begin
        tick_now = advance_tick(tick_now);
        send_pass(tick_now);
      end
      passes -= burst;
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  initial begin
    int sent;
    int passes;
    sb           = new();
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    current_tick <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    tick_now     = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no slot enabled, nothing ever dispatched
    send_pass(16'h0000);
    send_pass(16'hFFFF);
    send_pass(16'h5555);
    drain_results();

    // all three slots, zero periods, equal priorities: lowest index wins
    // count written with junk upper bits, unknown index written too
    write_reg(ppd_pkg::REG_TASK_COUNT, 16'hFFFF);
    write_reg(ppd_pkg::REG_PERIOD_0, 16'h0000);
    write_reg(ppd_pkg::REG_PERIOD_1, 16'h0000);
    write_reg(ppd_pkg::REG_PERIOD_2, 16'h0000);
    write_reg(ppd_pkg::REG_PRIORITY_0, 16'hAB80);
    write_reg(ppd_pkg::REG_PRIORITY_1, 16'hAB80);
    write_reg(ppd_pkg::REG_PRIORITY_2, 16'hAB80);
    write_reg(REG_UNUSED, 16'hFFFF);
    end_reg_writes();
    send_pass(16'h0000);
    send_pass(16'h0000);
    send_pass(16'h0001);
    send_pass(16'h0002);
    drain_results();

    // priority extremes, tie between slots 1 and 2
    write_reg(ppd_pkg::REG_PRIORITY_0, 16'h00FF);
    write_reg(ppd_pkg::REG_PRIORITY_1, 16'h0000);
    write_reg(ppd_pkg::REG_PRIORITY_2, 16'hFF00);
    write_reg(ppd_pkg::REG_PERIOD_1, 16'd10);
    end_reg_writes();
    send_pass(16'h0003);
    send_pass(16'h0004);
    send_pass(16'h0005);
    send_pass(16'h0006);
    drain_results();

    // slot 2 disabled, largest period on slot 0, tick wraps
    write_reg(ppd_pkg::REG_TASK_COUNT, 16'h0002);
    write_reg(ppd_pkg::REG_PERIOD_0, 16'hFFFF);
    write_reg(ppd_pkg::REG_PERIOD_1, 16'h0000);
    end_reg_writes();
    send_pass(16'hFFFF);
    send_pass(16'h0000);
    send_pass(16'h8000);
    drain_results();

    // slot 2 back in with its kept state, largest period there too
    write_reg(ppd_pkg::REG_TASK_COUNT, 16'h0003);
    write_reg(ppd_pkg::REG_PERIOD_2, 16'hFFFF);
    end_reg_writes();
    send_pass(16'hFFFE);
    send_pass(16'hFFFF);
    send_pass(16'h7FFF);
    drain_results();

    // random phases
    sent = 0;
    while (sent < RANDOM_PASSES) begin
      program_phase();
      if ($urandom_range(0, 7) == 0)
        tick_now = 16'hFFF0 + ppd_pkg::TICK_W'($urandom_range(0, 15));
      passes = $urandom_range(20, 120);
      run_phase(passes);
      sent += passes;
      drain_results();
    end

    // let any stray beat show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0)
      $display("periodic_priority_task_dispatcher_top_tb: done, clean");
    else
      $display("periodic_priority_task_dispatcher_top_tb: done, errors");
    $finish;
  end

endmodule
